@@ hdl/lru_pkg.sv @@
// package for the lru page replacement core
// widths, reset values and defaults shared by the interfaces and the core
// no dependencies
package lru_pkg;

   localparam int LRU_FRAMES    = 16;   // default number of page frames
   localparam int LRU_PAGE_W    = 16;   // page number width
   localparam int LRU_FIDX_W    = 4;    // frame index width on the result
   localparam int LRU_CNT_W     = 32;   // hit and fault counter width
   localparam int LRU_CFG_W     = 5;    // frames_in_use register width

   localparam logic [LRU_CFG_W-1:0] LRU_CFG_RESET = LRU_CFG_W'(16);

endpackage

@@ hdl/lru_if.sv @@
// valid/ready channel interfaces for the lru page replacement core
// depends on lru_pkg
interface lru_req_if;
   import lru_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [LRU_PAGE_W-1:0] page;

   modport source (output valid, output page, input ready);
   modport sink   (input valid, input page, output ready);
endinterface

interface lru_rsp_if;
   import lru_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [LRU_FIDX_W-1:0] frame_index;
   logic                  evicted_valid;
   logic [LRU_PAGE_W-1:0] evicted_page;
   logic [LRU_CNT_W-1:0]  hit_count;
   logic [LRU_CNT_W-1:0]  fault_count;

   modport source (output valid, output hit, output frame_index, output evicted_valid,
                   output evicted_page, output hit_count, output fault_count,
                   input ready);
   modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                   input evicted_page, input hit_count, input fault_count,
                   output ready);
endinterface

@@ hdl/lru_ram.sv @@
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module lru_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lru_page_replacement_core.sv @@
// lru page replacement core: frame pages and age ranks held in two rams
// depends on lru_pkg, lru_req_if, lru_rsp_if and lru_ram
//
// usage
//   req_if carries one page reference per transaction, rsp_if returns one
//   result per reference: hit or fault, the frame now holding the page, any
//   evicted page and saturating hit and fault counts. csr_wr_en/csr_wr_data
//   write frames_in_use; write it only while the core is idle.
// timing
//   one reference at a time. after acceptance the core walks the page and
//   age rams for the hit check and oldest-frame search, decides, walks
//   them again to rewrite ranks and then loads the result register; it
//   returns to idle before the next acceptance. each walk is paced by the
//   single read port of each ram, visited once per frame per pass.
// reset and stalls
//   reset empties all frames, clears the counters and sets frames_in_use to
//   16; no clearing pass is needed. a finished result waits in the output
//   register while the next reference is accepted and worked on; the core
//   holds before loading a new result while the old one is still stalled.
module lru_page_replacement_core #(
   parameter int FRAMES = lru_pkg::LRU_FRAMES
) (
   input  logic                         clock,
   input  logic                         reset,
   lru_req_if.sink                      req_if,
   lru_rsp_if.source                    rsp_if,
   input  logic                         csr_wr_en,
   input  logic [lru_pkg::LRU_CFG_W-1:0] csr_wr_data
);
   import lru_pkg::*;

   localparam int IW = $clog2(FRAMES);       // frame index and age rank width
   localparam int CW = $clog2(FRAMES + 1);   // occupancy and walk counter width

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_UPDATE,
      S_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic [LRU_CFG_W-1:0]  frames_in_use_ff, frames_in_use_in;
   logic [LRU_PAGE_W-1:0] page_ff, page_in;
   logic [CW-1:0]         limit_ff, limit_in;
   logic [CW-1:0]         occ_ff, occ_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IW-1:0]         idx_d_ff, idx_d_in;
   logic                  hit_found_ff, hit_found_in;
   logic [IW-1:0]         hit_idx_ff, hit_idx_in;
   logic [IW-1:0]         hit_age_ff, hit_age_in;
   logic [IW-1:0]         max_idx_ff, max_idx_in;
   logic [IW-1:0]         max_age_ff, max_age_in;
   logic [LRU_PAGE_W-1:0] max_page_ff, max_page_in;
   logic [IW-1:0]         tgt_ff, tgt_in;
   logic [IW-1:0]         old_ff, old_in;
   logic                  ev_valid_ff, ev_valid_in;
   logic [LRU_PAGE_W-1:0] ev_page_ff, ev_page_in;
   logic [LRU_CNT_W-1:0]  hits_ff, hits_in;
   logic [LRU_CNT_W-1:0]  faults_ff, faults_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [LRU_FIDX_W-1:0] rsp_fidx_ff, rsp_fidx_in;
   logic                  rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [LRU_PAGE_W-1:0] rsp_ev_page_ff, rsp_ev_page_in;
   logic [LRU_CNT_W-1:0]  rsp_hits_ff, rsp_hits_in;
   logic [LRU_CNT_W-1:0]  rsp_faults_ff, rsp_faults_in;

   logic                  pg_we;
   logic [LRU_PAGE_W-1:0] pg_rd;
   logic                  age_we;
   logic [IW-1:0]         age_wdata;
   logic [IW-1:0]         age_rd;
   logic [CW-1:0]         cfg_limit;
   logic                  req_take;

   // page and age memories, both walked by the same counter
   lru_ram #(.WIDTH(LRU_PAGE_W), .DEPTH(FRAMES)) u_page_ram (
      .clock   (clock),
      .wr_en   (pg_we),
      .wr_addr (tgt_in),
      .wr_data (page_ff),
      .rd_addr (cnt_ff[IW-1:0]),
      .rd_data (pg_rd)
   );

   lru_ram #(.WIDTH(IW), .DEPTH(FRAMES)) u_age_ram (
      .clock   (clock),
      .wr_en   (age_we),
      .wr_addr (idx_d_ff),
      .wr_data (age_wdata),
      .rd_addr (cnt_ff[IW-1:0]),
      .rd_data (age_rd)
   );

   // effective frame limit: zero acts as one, clamp to the frame count
   always_comb begin
      if (frames_in_use_ff == '0) begin
         cfg_limit = CW'(1);
      end else if (32'(frames_in_use_ff) > 32'(FRAMES)) begin
         cfg_limit = CW'(FRAMES);
      end else begin
         cfg_limit = CW'(frames_in_use_ff);
      end
   end

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_take     = req_if.valid && (state_ff == S_IDLE);

   // next state and datapath
   always_comb begin
      state_in         = state_ff;
      frames_in_use_in = csr_wr_en ? csr_wr_data : frames_in_use_ff;
      page_in          = page_ff;
      limit_in         = limit_ff;
      occ_in           = occ_ff;
      cnt_in           = cnt_ff;
      rd_vld_in        = 1'b0;
      idx_d_in         = cnt_ff[IW-1:0];
      hit_found_in     = hit_found_ff;
      hit_idx_in       = hit_idx_ff;
      hit_age_in       = hit_age_ff;
      max_idx_in       = max_idx_ff;
      max_age_in       = max_age_ff;
      max_page_in      = max_page_ff;
      tgt_in           = tgt_ff;
      old_in           = old_ff;
      ev_valid_in      = ev_valid_ff;
      ev_page_in       = ev_page_ff;
      hits_in          = hits_ff;
      faults_in        = faults_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_if.ready;
      rsp_hit_in       = rsp_hit_ff;
      rsp_fidx_in      = rsp_fidx_ff;
      rsp_ev_valid_in  = rsp_ev_valid_ff;
      rsp_ev_page_in   = rsp_ev_page_ff;
      rsp_hits_in      = rsp_hits_ff;
      rsp_faults_in    = rsp_faults_ff;
      pg_we            = 1'b0;
      age_we           = 1'b0;
      age_wdata        = '0;

      unique case (state_ff)
         // take a reference and start the search walk
         S_IDLE: begin
            if (req_take) begin
               page_in      = req_if.page;
               limit_in     = cfg_limit;
               cnt_in       = '0;
               hit_found_in = 1'b0;
               state_in     = S_SCAN;
            end
         end

         // walk occupied frames: first matching page, oldest frame within the limit
         S_SCAN: begin
            if (rd_vld_ff) begin
               if (!hit_found_ff && pg_rd == page_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = idx_d_ff;
                  hit_age_in   = age_rd;
               end
               if (CW'(idx_d_ff) < limit_ff && (idx_d_ff == '0 || age_rd > max_age_ff)) begin
                  max_idx_in  = idx_d_ff;
                  max_age_in  = age_rd;
                  max_page_in = pg_rd;
               end
            end
            if (cnt_ff == occ_ff) begin
               state_in = S_DECIDE;
            end else begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + CW'(1);
            end
         end

         // pick the frame, place the page on a miss, bump the counters
         S_DECIDE: begin
            cnt_in   = '0;
            state_in = S_UPDATE;
            priority if (hit_found_ff) begin
               tgt_in      = hit_idx_ff;
               old_in      = hit_age_ff;
               ev_valid_in = 1'b0;
               ev_page_in  = '0;
               if (hits_ff != '1) begin
                  hits_in = hits_ff + LRU_CNT_W'(1);
               end
            end else if (occ_ff < limit_ff) begin
               tgt_in      = occ_ff[IW-1:0];
               old_in      = occ_ff[IW-1:0];
               occ_in      = occ_ff + CW'(1);
               ev_valid_in = 1'b0;
               ev_page_in  = '0;
               pg_we       = 1'b1;
               if (faults_ff != '1) begin
                  faults_in = faults_ff + LRU_CNT_W'(1);
               end
            end else begin
               tgt_in      = max_idx_ff;
               old_in      = max_age_ff;
               ev_valid_in = 1'b1;
               ev_page_in  = max_page_ff;
               pg_we       = 1'b1;
               if (faults_ff != '1) begin
                  faults_in = faults_ff + LRU_CNT_W'(1);
               end
            end
         end

         // rewrite ranks: younger frames age by one, the used frame becomes newest
         S_UPDATE: begin
            if (rd_vld_ff) begin
               age_we = 1'b1;
               if (idx_d_ff == tgt_ff) begin
                  age_wdata = '0;
               end else if (age_rd < old_ff) begin
                  age_wdata = age_rd + IW'(1);
               end else begin
                  age_wdata = age_rd;
               end
            end
            if (cnt_ff == occ_ff) begin
               state_in = S_OUT;
            end else begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + CW'(1);
            end
         end

         // load the result register once it is free
         S_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_hit_in      = hit_found_ff;
               rsp_fidx_in     = LRU_FIDX_W'(tgt_ff);
               rsp_ev_valid_in = ev_valid_ff;
               rsp_ev_page_in  = ev_page_ff;
               rsp_hits_in     = hits_ff;
               rsp_faults_in   = faults_ff;
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         frames_in_use_ff <= LRU_CFG_RESET;
         occ_ff           <= '0;
         rd_vld_ff        <= 1'b0;
         hits_ff          <= '0;
         faults_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         frames_in_use_ff <= frames_in_use_in;
         occ_ff           <= occ_in;
         rd_vld_ff        <= rd_vld_in;
         hits_ff          <= hits_in;
         faults_ff        <= faults_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      page_ff         <= page_in;
      limit_ff        <= limit_in;
      cnt_ff          <= cnt_in;
      idx_d_ff        <= idx_d_in;
      hit_found_ff    <= hit_found_in;
      hit_idx_ff      <= hit_idx_in;
      hit_age_ff      <= hit_age_in;
      max_idx_ff      <= max_idx_in;
      max_age_ff      <= max_age_in;
      max_page_ff     <= max_page_in;
      tgt_ff          <= tgt_in;
      old_ff          <= old_in;
      ev_valid_ff     <= ev_valid_in;
      ev_page_ff      <= ev_page_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_fidx_ff     <= rsp_fidx_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
      rsp_hits_ff     <= rsp_hits_in;
      rsp_faults_ff   <= rsp_faults_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.hit           = rsp_hit_ff;
   assign rsp_if.frame_index   = rsp_fidx_ff;
   assign rsp_if.evicted_valid = rsp_ev_valid_ff;
   assign rsp_if.evicted_page  = rsp_ev_page_ff;
   assign rsp_if.hit_count     = rsp_hits_ff;
   assign rsp_if.fault_count   = rsp_faults_ff;

   // occupancy never runs past the frame count
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= 32'(FRAMES))
      else $error("occupancy beyond frame count");

   // a hit never evicts
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !(rsp_if.hit && rsp_if.evicted_valid))
      else $error("hit reported with eviction");

   // the victim always lies inside the frame limit
   a_victim_in_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && !hit_found_ff && occ_ff >= limit_ff)
         |-> (CW'(max_idx_ff) < limit_ff))
      else $error("victim frame outside limit");

   // occupancy only moves in the decide step
   a_occ_decide: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DECIDE) |=> $stable(occ_ff))
      else $error("occupancy changed outside decide");

endmodule
